/* design/mrps_pkg.sv */
package mrps_pkg;

  localparam int CHANNELS_DEF   = 512;
  localparam int PROG_DEPTH_DEF = 1024;

  localparam int CHAN_W  = 9;
  localparam int ADDR_W  = 10;
  localparam int VALUE_W = 16;

  // command codes
  localparam logic [1:0] CMD_WRITE   = 2'd0;
  localparam logic [1:0] CMD_BIND    = 2'd1;
  localparam logic [1:0] CMD_DISABLE = 2'd2;
  localparam logic [1:0] CMD_TICK    = 2'd3;

  // program opcodes
  localparam logic [VALUE_W-1:0] S_SET  = 16'd1;
  localparam logic [VALUE_W-1:0] S_UP   = 16'd2;
  localparam logic [VALUE_W-1:0] S_DOWN = 16'd3;
  localparam logic [VALUE_W-1:0] S_WAIT = 16'd4;
  localparam logic [VALUE_W-1:0] S_LOOP = 16'd5;
  localparam logic [VALUE_W-1:0] S_STOP = 16'd6;

  typedef struct packed {
    logic [1:0]                cmd;
    logic [CHAN_W-1:0]         channel;
    logic [ADDR_W-1:0]         prog_addr;
    logic signed [VALUE_W-1:0] prog_word;
  } req_t;

  typedef struct packed {
    logic [CHAN_W-1:0]         out_channel;
    logic signed [VALUE_W-1:0] out_value;
    logic                      stopped;
  } rsp_t;

endpackage

/* design/multichannel_ramp_pattern_sequencer.sv */
// channel  | valid     | stall     | payload
// request  | req_valid | req_stall | req (mrps_pkg::req_t)
// response | rsp_valid | rsp_stall | rsp (mrps_pkg::rsp_t)
//
// one transaction at a time: write, bind and disable finish in ST_REDUCE; a tick reads
// the channel memory, then the program memory three times, and a disabled channel skips the program reads;
// with PROG_DEPTH below 1024 each subtraction of PROG_DEPTH from the address adds a pass through ST_REDUCE.
// after reset a clearing pass runs through every entry of the channel memory;
// req_stall stays high meanwhile. a tick result waits in the output register
// while rsp_stall is high, and a new request is taken once the tick has finished.
module multichannel_ramp_pattern_sequencer #(
  parameter int CHANNELS   = mrps_pkg::CHANNELS_DEF,
  parameter int PROG_DEPTH = mrps_pkg::PROG_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  mrps_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output mrps_pkg::rsp_t rsp
);
  import mrps_pkg::*;

  localparam int AW = $clog2(PROG_DEPTH);
  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int RW = (AW > ADDR_W) ? AW : ADDR_W;

  typedef struct packed {
    logic               en;
    logic [AW-1:0]      start;
    logic [AW-1:0]      ptr;
    logic [VALUE_W-1:0] count;
    logic [VALUE_W-1:0] value;
  } chan_t;

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_REDUCE = 7'b0000100,
    ST_CHAN   = 7'b0001000,
    ST_OP     = 7'b0010000,
    ST_W1     = 7'b0100000,
    ST_EXEC   = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  logic [CW-1:0]      clr_idx;
  logic [1:0]         cmd_r;
  logic [CHAN_W-1:0]  ch_r;
  logic [VALUE_W-1:0] word_r;
  logic [RW-1:0]      red;
  logic [AW-1:0]      pa;
  logic [VALUE_W-1:0] op_r;
  logic [VALUE_W-1:0] w1_r;

  chan_t              chan_mem [CHANNELS];
  chan_t              chan_rd;
  logic [VALUE_W-1:0] prog_mem [PROG_DEPTH];
  logic [VALUE_W-1:0] prog_rd;

  logic [CW-1:0]      ch_idx;
  logic               ch_ok;
  logic               red_hi;
  logic [CW-1:0]      ch_addr;
  logic               ch_we;
  logic               ch_re;
  chan_t              ch_wdata;
  logic [AW-1:0]      pm_addr;
  logic               pm_we;
  logic               pm_re;
  logic [AW-1:0]      a0;
  logic               exec_fire;

  chan_t              nxt;
  logic               stopped_n;
  logic signed [16:0] v17;
  logic signed [16:0] w1_17;
  logic signed [16:0] w2_17;
  logic signed [16:0] sum17;
  logic signed [16:0] dif17;
  logic signed [16:0] neg17;
  logic signed [16:0] c1_17;
  logic [VALUE_W-1:0] c1;

  // a + b modulo PROG_DEPTH, for a below PROG_DEPTH and b at most PROG_DEPTH
  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] a, logic [AW:0] b);
    logic [AW+1:0] s;
    s = {2'b00, a} + {1'b0, b};
    if (s >= (AW+2)'(PROG_DEPTH)) begin
      s = s - (AW+2)'(PROG_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign ch_idx    = CW'(32'(ch_r));
  assign ch_ok     = 32'(ch_r) < CHANNELS;
  assign red_hi    = 32'(red) >= PROG_DEPTH;
  assign req_stall = (state != ST_IDLE);
  assign exec_fire = (state == ST_EXEC) && (!rsp_valid || !rsp_stall);
  assign a0        = wrap_add(chan_rd.start, {1'b0, chan_rd.ptr});

  // execution of one program step
  always_comb begin
    nxt       = chan_rd;
    stopped_n = 1'b0;
    v17       = {chan_rd.value[VALUE_W-1], chan_rd.value};
    w1_17     = {w1_r[VALUE_W-1], w1_r};
    w2_17     = {prog_rd[VALUE_W-1], prog_rd};
    sum17     = v17 + w2_17;
    dif17     = v17 - w2_17;
    neg17     = -w2_17;
    c1        = chan_rd.count + 16'd1;
    c1_17     = {1'b0, c1};
    case (op_r)
      S_SET: begin
        nxt.value = w1_r;
        nxt.ptr   = wrap_add(chan_rd.ptr, (AW+1)'(2));
      end
      S_UP: begin
        if (sum17 <= w1_17) begin
          if (!prog_rd[VALUE_W-1]) begin
            nxt.value = sum17[VALUE_W-1:0];
          end else if (c1_17 > neg17) begin
            nxt.count = '0;
            nxt.value = chan_rd.value + 16'd1;
          end else begin
            nxt.count = c1;
          end
        end else begin
          nxt.ptr = wrap_add(chan_rd.ptr, (AW+1)'(3));
        end
      end
      S_DOWN: begin
        if (dif17 >= w1_17) begin
          if (!prog_rd[VALUE_W-1]) begin
            nxt.value = dif17[VALUE_W-1:0];
          end else if (c1_17 > neg17) begin
            nxt.count = '0;
            nxt.value = chan_rd.value - 16'd1;
          end else begin
            nxt.count = c1;
          end
        end else begin
          nxt.ptr = wrap_add(chan_rd.ptr, (AW+1)'(3));
        end
      end
      S_WAIT: begin
        if (c1_17 >= w1_17) begin
          nxt.count = '0;
          nxt.ptr   = wrap_add(chan_rd.ptr, (AW+1)'(2));
        end else begin
          nxt.count = c1;
        end
      end
      S_LOOP: begin
        nxt.ptr = '0;
      end
      S_STOP: begin
        stopped_n = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // memory port control
  always_comb begin
    ch_addr  = (state == ST_CLEAR) ? clr_idx : ch_idx;
    ch_we    = 1'b0;
    ch_re    = 1'b0;
    ch_wdata = '0;
    pm_we    = 1'b0;
    pm_re    = 1'b0;
    pm_addr  = wrap_add(pa, (AW+1)'(1));
    case (state)
      ST_CLEAR: begin
        ch_we = 1'b1;
      end
      ST_REDUCE: begin
        pm_addr = red[AW-1:0];
        if (!red_hi) begin
          if (cmd_r == CMD_WRITE) begin
            pm_we = 1'b1;
          end else if (ch_ok) begin
            if (cmd_r == CMD_BIND) begin
              ch_we          = 1'b1;
              ch_wdata.en    = 1'b1;
              ch_wdata.start = red[AW-1:0];
            end else if (cmd_r == CMD_DISABLE) begin
              ch_we = 1'b1;
            end else begin
              ch_re = 1'b1;
            end
          end
        end
      end
      ST_CHAN: begin
        pm_addr = a0;
        pm_re   = chan_rd.en;
      end
      ST_OP, ST_W1: begin
        pm_re = 1'b1;
      end
      ST_EXEC: begin
        ch_we    = exec_fire;
        ch_wdata = nxt;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ch_we) begin
      chan_mem[ch_addr] <= ch_wdata;
    end
    if (ch_re) begin
      chan_rd <= chan_mem[ch_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (pm_we) begin
      prog_mem[pm_addr] <= word_r;
    end else if (pm_re) begin
      prog_rd <= prog_mem[pm_addr];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_idx == CW'(CHANNELS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_valid) begin
          state_next = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (!red_hi) begin
          state_next = ch_re ? ST_CHAN : ST_IDLE;
        end
      end
      ST_CHAN: begin
        state_next = chan_rd.en ? ST_OP : ST_IDLE;
      end
      ST_OP: begin
        state_next = ST_W1;
      end
      ST_W1: begin
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (exec_fire) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (exec_fire) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req_valid) begin
      cmd_r  <= req.cmd;
      ch_r   <= req.channel;
      word_r <= req.prog_word;
      red    <= RW'(req.prog_addr);
    end else if (state == ST_REDUCE && red_hi) begin
      red <= red - RW'(PROG_DEPTH);
    end
    if (state == ST_CHAN) begin
      pa <= a0;
    end else if (state == ST_OP || state == ST_W1) begin
      pa <= pm_addr;
    end
    if (state == ST_OP) begin
      op_r <= prog_rd;
    end
    if (state == ST_W1) begin
      w1_r <= prog_rd;
    end
    if (exec_fire) begin
      rsp.out_channel <= ch_r;
      rsp.out_value   <= nxt.value;
      rsp.stopped     <= stopped_n;
    end
  end

endmodule
